>>> hdl/mtb_pkg.sv
// Package for the timer bank: sizes, opcodes, result codes and the entry record.
// No dependencies; multi_timer_bank and its testbench import it.
`default_nettype none

package mtb_pkg;

    // Table size and derived widths
    localparam int NUM_TIMERS = 8;
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;  // entry address
    localparam int CW = $clog2(NUM_TIMERS + 1);                     // entry count

    // Opcodes
    localparam logic [2:0] OP_DEFINE  = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_RDCOUNT = 3'd2;
    localparam logic [2:0] OP_RDSTATE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_ENABLE  = 3'd5;
    localparam logic [2:0] OP_DISABLE = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Timer state codes
    localparam logic [2:0] TS_ABSENT      = 3'd0;
    localparam logic [2:0] TS_ALARM_FIRED = 3'd1;
    localparam logic [2:0] TS_ALARM_IDLE  = 3'd2;
    localparam logic [2:0] TS_FREE_STOP   = 3'd3;
    localparam logic [2:0] TS_FREE_RUN    = 3'd4;

    // Flag bit positions
    localparam int F_MODE    = 0;
    localparam int F_REPEAT  = 1;
    localparam int F_ENABLED = 2;
    localparam int F_FIRED   = 3;

    // Count reported for an absent id
    localparam logic [31:0] ABSENT_COUNT = 32'd255;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] period;
        logic [7:0]  ident;
        logic [3:0]  flags;
    } t_entry;

endpackage

`default_nettype wire

>>> hdl/mtb_if.sv
// Valid/ready channels of the timer bank: command words in, result words out.
// No dependencies.
`default_nettype none

interface mtb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  timer_id;
    logic [31:0] amount_ms;
    logic        timer_mode;
    logic        repeat_flag;

    modport source (output valid, opcode, timer_id, amount_ms, timer_mode, repeat_flag,
                    input ready);
    modport sink   (input valid, opcode, timer_id, amount_ms, timer_mode, repeat_flag,
                    output ready);
endinterface

interface mtb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] count_value;
    logic [2:0]  timer_state;

    modport source (output valid, status, count_value, timer_state, input ready);
    modport sink   (input valid, status, count_value, timer_state, output ready);
endinterface

`default_nettype wire

>>> hdl/mtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/multi_timer_bank.sv
// Timer bank top level: sequencer that walks the entry RAM once per command other than define and the unused opcode.
// Depends on mtb_pkg, mtb_if (mtb_in_if, mtb_out_if) and mtb_ram.
//
// Usage:
//   i_cmd carries one command word (opcode, timer_id, amount_ms, timer_mode,
//   repeat_flag); o_rsp returns exactly one result word per command
//   (status, count_value, timer_state). A word moves when valid and ready
//   are both high at a rising edge of i_clk.
//   All timer entries live in one RAM with a registered read. Define and the
//   unused opcode write or skip the table and go straight to the done
//   state. Every other opcode reads each defined entry, one per cycle
//   through the single read port, and, rdcount apart, updates and writes
//   it back; the result is registered once the walk has ended.
//   i_cmd.ready is high only while no command is in flight, so one command
//   is worked at a time; a new command may be taken while the previous
//   result still waits in the output register.
//   When o_rsp is stalled the finished command waits until the output
//   register frees; the result word holds steady meanwhile.
//   i_rst_n (synchronous, active low) empties the table by zeroing the
//   defined-entry count; the RAM needs no clearing pass, since only
//   entries below that count are ever read.
`default_nettype none

module multi_timer_bank
    import mtb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mtb_in_if.sink      i_cmd,
    mtb_out_if.source   o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int EW = $bits(t_entry);

    // control state
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_rd_vld, n_rd_vld;
    logic [AW-1:0] r_pend_idx, n_pend_idx;
    logic          r_out_vld, n_out_vld;

    // command and accumulated results
    logic [2:0]    r_op, n_op;
    logic [7:0]    r_id, n_id;
    logic [31:0]   r_amt, n_amt;
    logic          r_full, n_full;
    logic          r_found, n_found;
    logic [31:0]   r_countv, n_countv;
    logic [2:0]    r_tstate, n_tstate;

    // output word
    logic [1:0]    r_out_status, n_out_status;
    logic [31:0]   r_out_count, n_out_count;
    logic [2:0]    r_out_tstate, n_out_tstate;

    // RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;
    logic [EW-1:0] ram_rbits;

    // entry update
    t_entry        upd;
    logic          match;
    logic [31:0]   sum;

    logic          cmd_acc;
    logic          rsp_free;

    assign cmd_acc  = i_cmd.valid && i_cmd.ready;
    assign rsp_free = !r_out_vld || o_rsp.ready;
    assign ram_rdata = t_entry'(ram_rbits);

    mtb_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    // modify the entry that came back from the RAM
    always_comb begin
        upd   = ram_rdata;
        match = (ram_rdata.ident == r_id);
        sum   = ram_rdata.count + r_amt;
        case (r_op)
            OP_TICK: begin
                if (ram_rdata.flags[F_ENABLED]) begin
                    upd.count = sum;
                    if (!ram_rdata.flags[F_MODE] && (sum >= ram_rdata.period)) begin
                        upd.count = '0;
                        if (!ram_rdata.flags[F_REPEAT]) begin
                            upd.flags[F_ENABLED] = 1'b0;
                        end
                        upd.flags[F_FIRED] = 1'b1;
                    end
                end
            end
            OP_RDSTATE: begin
                if (match && !ram_rdata.flags[F_MODE]) begin
                    upd.flags[F_FIRED] = 1'b0;
                end
            end
            OP_CLEAR: begin
                if (match) begin
                    upd.count          = '0;
                    upd.flags[F_FIRED] = 1'b0;
                end
            end
            OP_ENABLE: begin
                if (match) begin
                    upd.flags[F_ENABLED] = 1'b1;
                end
            end
            OP_DISABLE: begin
                if (match) begin
                    upd.flags[F_ENABLED] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_rd_idx     = r_rd_idx;
        n_rd_vld     = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_out_vld    = r_out_vld;
        n_op         = r_op;
        n_id         = r_id;
        n_amt        = r_amt;
        n_full       = r_full;
        n_found      = r_found;
        n_countv     = r_countv;
        n_tstate     = r_tstate;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_tstate = r_out_tstate;

        ram_we    = 1'b0;
        ram_waddr = r_pend_idx;
        ram_wdata = upd;
        ram_re    = 1'b0;
        ram_raddr = r_rd_idx[AW-1:0];

        // output register drains
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_op     = i_cmd.opcode;
                    n_id     = i_cmd.timer_id;
                    n_amt    = i_cmd.amount_ms;
                    n_full   = 1'b0;
                    n_found  = 1'b0;
                    n_countv = '0;
                    n_tstate = TS_ABSENT;
                    n_rd_idx = '0;
                    if (i_cmd.opcode == OP_DEFINE) begin
                        // new entry goes straight into the next free slot
                        if (r_total >= CW'(NUM_TIMERS)) begin
                            n_full = 1'b1;
                        end else begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_total[AW-1:0];
                            ram_wdata.count  = '0;
                            ram_wdata.period = i_cmd.amount_ms;
                            ram_wdata.ident  = i_cmd.timer_id;
                            ram_wdata.flags  = '0;
                            ram_wdata.flags[F_MODE]    = i_cmd.timer_mode;
                            ram_wdata.flags[F_REPEAT]  = i_cmd.repeat_flag;
                            ram_wdata.flags[F_ENABLED] = 1'b1;
                            n_total = r_total + CW'(1);
                        end
                        n_state = S_DONE;
                    end else if (i_cmd.opcode == OP_TICK || i_cmd.opcode == OP_RDCOUNT ||
                                 i_cmd.opcode == OP_RDSTATE || i_cmd.opcode == OP_CLEAR ||
                                 i_cmd.opcode == OP_ENABLE || i_cmd.opcode == OP_DISABLE) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                // issue the next read
                if (r_rd_idx < r_total) begin
                    ram_re     = 1'b1;
                    n_rd_vld   = 1'b1;
                    n_pend_idx = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + CW'(1);
                end
                // write back the entry read last cycle; reads of different
                // entries never overlap a write of the same one
                if (r_rd_vld) begin
                    ram_we    = (r_op != OP_RDCOUNT);
                    ram_waddr = r_pend_idx;
                    ram_wdata = upd;
                    if (match) begin
                        n_found = 1'b1;
                        if (r_op == OP_RDCOUNT && !r_found) begin
                            n_countv = ram_rdata.count;
                        end
                        if (r_op == OP_RDSTATE) begin
                            if (!ram_rdata.flags[F_MODE]) begin
                                n_tstate = ram_rdata.flags[F_FIRED] ? TS_ALARM_FIRED
                                                                    : TS_ALARM_IDLE;
                            end else begin
                                n_tstate = ram_rdata.flags[F_ENABLED] ? TS_FREE_RUN
                                                                      : TS_FREE_STOP;
                            end
                        end
                    end
                end
                if (!r_rd_vld && !(r_rd_idx < r_total)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (rsp_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_count  = '0;
                    n_out_tstate = TS_ABSENT;
                    case (r_op) inside
                        OP_DEFINE: begin
                            if (r_full) begin
                                n_out_status = ST_FULL;
                            end
                        end
                        OP_RDCOUNT: begin
                            n_out_count = r_found ? r_countv : ABSENT_COUNT;
                            if (!r_found) begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        OP_RDSTATE: begin
                            n_out_tstate = r_tstate;
                            if (!r_found) begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        OP_CLEAR, OP_ENABLE, OP_DISABLE: begin
                            if (!r_found) begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_op         <= n_op;
        r_id         <= n_id;
        r_amt        <= n_amt;
        r_full       <= n_full;
        r_found      <= n_found;
        r_countv     <= n_countv;
        r_tstate     <= n_tstate;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_tstate <= n_out_tstate;
    end

    // ports
    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.count_value = r_out_count;
    assign o_rsp.timer_state = r_out_tstate;

    // checks
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(NUM_TIMERS))
        else $error("defined entry count above table size");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_WALK))
        else $error("RAM read data pending outside the walk");

    a_pend_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (CW'(r_pend_idx) < r_total))
        else $error("write-back to an undefined entry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != S_IDLE))
        else $error("command accepted but sequencer stayed idle");

endmodule

`default_nettype wire

>>> verif/multi_timer_bank_tb.sv
// Self-checking testbench for multi_timer_bank: directed and random command words,
// predicted against a behavioral model of the timer table, with random stalls on both channels.
// Depends on mtb_pkg, mtb_if (mtb_in_if, mtb_out_if) and the multi_timer_bank RTL.

module multi_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtb_pkg::*;

    // The opcode that the block leaves unused
    localparam logic [2:0] OP_UNUSED     = 3'd7;
    localparam int         RANDOM_WORDS  = 1525;
    localparam int         WATCHDOG_MAX  = 2000;
    localparam int         DRAIN_CYCLES  = 4 * (NUM_TIMERS + 3);
    localparam int         PRINT_CAP     = 40;

    // One predicted result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] count_value;
        logic [2:0]  timer_state;
    } t_timer_rsp;

    // Timer table model and the queue of result words still owed by the block
    class timer_scoreboard;
        logic [31:0] tmr_count  [NUM_TIMERS];
        logic [31:0] tmr_period [NUM_TIMERS];
        logic [7:0]  tmr_ident  [NUM_TIMERS];
        logic [3:0]  tmr_flags  [NUM_TIMERS];
        int unsigned live_total;
        t_timer_rsp  owed_rsp[$];
        int unsigned mismatches;
        int unsigned words_checked;
        int unsigned fired_reads;
        int unsigned full_defines;

        function new();
            foreach (tmr_count[i]) begin
                tmr_count[i]  = '0;
                tmr_period[i] = '0;
                tmr_ident[i]  = '0;
                tmr_flags[i]  = '0;
            end
            live_total    = 0;
            mismatches    = 0;
            words_checked = 0;
            fired_reads   = 0;
            full_defines  = 0;
        endfunction

        // Apply one accepted command to the table and queue the word it should produce
        function void note_command(input logic [2:0] op, input logic [7:0] id,
                                   input logic [31:0] amt, input logic mode,
                                   input logic rep);
            t_timer_rsp rsp;
            bit         hit;
            rsp.status      = ST_OK;
            rsp.count_value = '0;
            rsp.timer_state = TS_ABSENT;
            hit             = 1'b0;
            case (op)
                OP_DEFINE: begin
                    if (live_total >= NUM_TIMERS) begin
                        rsp.status = ST_FULL;
                        full_defines++;
                    end else begin
                        tmr_ident[live_total]  = id;
                        tmr_period[live_total] = amt;
                        tmr_count[live_total]  = '0;
                        tmr_flags[live_total]  = '0;
                        tmr_flags[live_total][F_MODE]    = mode;
                        tmr_flags[live_total][F_REPEAT]  = rep;
                        tmr_flags[live_total][F_ENABLED] = 1'b1;
                        live_total++;
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < live_total; i++) begin
                        if (tmr_flags[i][F_ENABLED]) begin
                            tmr_count[i] = tmr_count[i] + amt;
                            // alarm reached: reload, flag it, drop out unless repeating
                            if (!tmr_flags[i][F_MODE] && tmr_count[i] >= tmr_period[i]) begin
                                tmr_count[i] = '0;
                                if (!tmr_flags[i][F_REPEAT])
                                    tmr_flags[i][F_ENABLED] = 1'b0;
                                tmr_flags[i][F_FIRED] = 1'b1;
                            end
                        end
                    end
                end
                OP_RDCOUNT: begin
                    rsp.count_value = ABSENT_COUNT;
                    // first match wins
                    for (int i = 0; i < live_total; i++) begin
                        if (!hit && tmr_ident[i] == id) begin
                            rsp.count_value = tmr_count[i];
                            hit = 1'b1;
                        end
                    end
                    if (!hit) rsp.status = ST_NOT_FOUND;
                end
                OP_RDSTATE: begin
                    // last match reports; every matching alarm loses its fired flag
                    for (int i = 0; i < live_total; i++) begin
                        if (tmr_ident[i] == id) begin
                            hit = 1'b1;
                            if (!tmr_flags[i][F_MODE]) begin
                                if (tmr_flags[i][F_FIRED]) begin
                                    rsp.timer_state = TS_ALARM_FIRED;
                                    tmr_flags[i][F_FIRED] = 1'b0;
                                end else begin
                                    rsp.timer_state = TS_ALARM_IDLE;
                                end
                            end else begin
                                rsp.timer_state = tmr_flags[i][F_ENABLED] ? TS_FREE_RUN
                                                                          : TS_FREE_STOP;
                            end
                        end
                    end
                    if (!hit) rsp.status = ST_NOT_FOUND;
                    if (rsp.timer_state == TS_ALARM_FIRED) fired_reads++;
                end
                OP_CLEAR, OP_ENABLE, OP_DISABLE: begin
                    for (int i = 0; i < live_total; i++) begin
                        if (tmr_ident[i] == id) begin
                            hit = 1'b1;
                            if (op == OP_CLEAR) begin
                                tmr_count[i] = '0;
                                tmr_flags[i][F_FIRED] = 1'b0;
                            end else if (op == OP_ENABLE) begin
                                tmr_flags[i][F_ENABLED] = 1'b1;
                            end else begin
                                tmr_flags[i][F_ENABLED] = 1'b0;
                            end
                        end
                    end
                    if (!hit) rsp.status = ST_NOT_FOUND;
                end
                default: ;
            endcase
            owed_rsp.push_back(rsp);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        endtask

        // Compare a received word with the oldest one owed
        task check_result(input logic [1:0] status, input logic [31:0] count_value,
                          input logic [2:0] timer_state);
            t_timer_rsp want;
            words_checked++;
            if (owed_rsp.size() == 0) begin
                report_mismatch("unrequested result word, status", 32'(status), '0);
            end else begin
                want = owed_rsp.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (count_value !== want.count_value)
                    report_mismatch("count_value", count_value, want.count_value);
                if (timer_state !== want.timer_state)
                    report_mismatch("timer_state", 32'(timer_state), 32'(want.timer_state));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    mtb_in_if  cmd_if();
    mtb_out_if rsp_if();

    multi_timer_bank u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    timer_scoreboard sb;
    logic [7:0]      def_ids [NUM_TIMERS];
    int              burst_left;
    int unsigned     words_sent;
    int unsigned     idle_cycles;
    int unsigned     rx_cycle;
    int              rx_style;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Send one command word; the sender runs in bursts with random gaps between them
    task automatic send_cmd(input logic [2:0] op, input logic [7:0] id,
                            input logic [31:0] amt, input logic mode, input logic rep);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= op;
        cmd_if.timer_id    <= id;
        cmd_if.amount_ms   <= amt;
        cmd_if.timer_mode  <= mode;
        cmd_if.repeat_flag <= rep;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        sb.note_command(op, id, amt, mode, rep);
        words_sent++;
    endtask

    // Mostly ids that exist, sometimes anything
    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 99) < 80)
            return def_ids[$urandom_range(0, NUM_TIMERS - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly small steps so alarms fire often, now and then a huge one that wraps
    function automatic logic [31:0] pick_amount();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return 32'($urandom_range(0, 60));
        if (sel < 85) return 32'($urandom_range(0, 1000));
        return $urandom;
    endfunction

    // Empty table, then a full one with duplicates, period extremes and both modes
    task automatic run_directed();
        logic [7:0]  ids  [NUM_TIMERS];
        logic [31:0] pers [NUM_TIMERS];
        logic        mods [NUM_TIMERS];
        logic        reps [NUM_TIMERS];
        ids  = '{8'h00, 8'hFF, 8'h5A, 8'h5A, 8'hA5, 8'h33,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        pers = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd37, 32'hFFFF_FFFF, 32'd0,
                 32'($urandom_range(1, 200)), 32'($urandom_range(1, 200))};
        mods = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        reps = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

        // nothing defined yet: every lookup misses
        send_cmd(OP_TICK,    8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_cmd(OP_RDCOUNT, 8'h00, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_RDSTATE, 8'hFF, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_CLEAR,   8'h12, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_UNUSED,  8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

        for (int i = 0; i < NUM_TIMERS; i++) begin
            def_ids[i] = ids[i];
            send_cmd(OP_DEFINE, ids[i], pers[i], mods[i], reps[i]);
        end
        send_cmd(OP_DEFINE, 8'h77, 32'hFFFF_FFFF, 1'b1, 1'b1);

        // period-zero and short alarms fire; duplicate ids resolve first/last
        send_cmd(OP_TICK,    8'h00, 32'd40, 1'b0, 1'b0);
        send_cmd(OP_RDSTATE, 8'h5A, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_RDCOUNT, 8'h5A, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_RDSTATE, 8'h00, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_TICK,    8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_cmd(OP_RDCOUNT, 8'hFF, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_DISABLE, 8'h5A, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_ENABLE,  8'h5A, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_CLEAR,   8'h00, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_DISABLE, 8'hFF, 32'd0, 1'b0, 1'b0);
        send_cmd(OP_RDSTATE, 8'hFF, 32'd0, 1'b0, 1'b0);
    endtask

    // Random mix weighted toward ticks and reads of live timers
    task automatic run_random(input int count);
        int unsigned sel;
        logic [2:0]  op;
        logic [31:0] amt;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if      (sel < 35) op = OP_TICK;
            else if (sel < 50) op = OP_RDCOUNT;
            else if (sel < 65) op = OP_RDSTATE;
            else if (sel < 73) op = OP_CLEAR;
            else if (sel < 83) op = OP_ENABLE;
            else if (sel < 92) op = OP_DISABLE;
            else if (sel < 97) op = OP_DEFINE;
            else               op = OP_UNUSED;
            amt = (op == OP_TICK) ? pick_amount() : $urandom;
            send_cmd(op, pick_id(), amt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: check accepted words, stall in phases of changing style
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result(rsp_if.status, rsp_if.count_value, rsp_if.timer_state);
        if (rx_cycle % 150 == 0)
            rx_style = $urandom_range(0, 2);
        case (rx_style)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= (rx_cycle % 5 == 0);
        endcase
        rx_cycle++;
    end

    // Watchdog: too long without any word moving on either channel
    always @(posedge i_clk) begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
        else if (i_rst_n === 1'b1)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Main sequence
    initial begin
        cmd_if.valid       = 1'b0;
        cmd_if.opcode      = OP_DEFINE;
        cmd_if.timer_id    = '0;
        cmd_if.amount_ms   = '0;
        cmd_if.timer_mode  = 1'b0;
        cmd_if.repeat_flag = 1'b0;
        rsp_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        burst_left         = 0;
        words_sent         = 0;
        idle_cycles        = 0;
        rx_cycle           = 0;
        rx_style           = 0;
        sb                 = new();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_WORDS);
        cmd_if.valid <= 1'b0;

        // drain the owed results, then give stray words a chance to show up
        while (sb.owed_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d defines refused on a full table), checked %0d results.",
                 words_sent, sb.full_defines, sb.words_checked);
        $display("Alarm fires seen on state reads: %0d; mismatches: %0d.",
                 sb.fired_reads, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
